@@ sv/mtvc_pkg.sv @@
package mtvc_pkg;

  // default detection window depth
  localparam int unsigned WINDOW_DEPTH_DEF = 32;

  // item codes
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LOST = 2'd0;
  localparam logic [1:0] REG_CONE = 2'd1;
  localparam logic [1:0] REG_RATE = 2'd2;
  localparam logic [1:0] REG_WIN  = 2'd3;

  // shared multiplier operand and accumulator widths
  localparam int unsigned MUL_W = 33;
  localparam int unsigned ACC_W = 68;

  // marker velocity divider
  localparam int unsigned DIV_NUM_W = 46;
  localparam int unsigned MV_W      = 14;
  localparam int unsigned DIV_QB    = 13;

  // filter weights, Q10
  localparam int W_PAD_NEW = 717;
  localparam int W_PAD_OLD = 307;
  localparam int W_POS_NEW = 819;
  localparam int W_POS_OLD = 205;
  // marker velocity gains
  localparam int K_DAMP    = 614;
  localparam int K_DIFF    = 40960;
  // limits
  localparam int CLIP_MV   = 5000;
  localparam int LIM_VEL   = 60000;
  localparam int LIM_PAD_LO = -65536;
  localparam int LIM_PAD_HI = 65535;

  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_NEG  = 2'd1,
    MAC_ADD  = 2'd2,
    MAC_SUB  = 2'd3
  } mac_op_e;

  typedef struct packed {
    logic    en;
    mac_op_e op;
  } mac_ctl_t;

  // divide by 2^k, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                       input int unsigned k);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    q = (mag + (ACC_W'(1) << (k - 1))) >> k;
    return v[ACC_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v,
                                                     input logic signed [ACC_W-1:0] lo,
                                                     input logic signed [ACC_W-1:0] hi);
    logic signed [ACC_W-1:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

endpackage

@@ sv/mtvc_mac.sv @@
module mtvc_mac
  import mtvc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctl_t                ctl_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   acc_q;

  assign prod   = a_i * b_i;
  assign prod_x = ACC_W'(prod);

  always_comb begin
    case (ctl_i.op)
      MAC_LOAD: acc_d = prod_x;
      MAC_NEG:  acc_d = -prod_x;
      MAC_ADD:  acc_d = acc_q + prod_x;
      MAC_SUB:  acc_d = acc_q - prod_x;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ sv/mtvc_div.sv @@
module mtvc_div
  import mtvc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DIV_NUM_W-1:0] num_i,
  input  logic [15:0]                 dt_i,
  output logic                        done_o,
  output logic signed [MV_W-1:0]      quo_o
);

  // quotient = round(num / (1024*dt)), clipped to +-CLIP_MV, one bit a cycle

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_NUM_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] dsh_q;
  logic [DIV_QB-1:0]    q_q;
  logic [3:0]           cnt_q;
  logic                 neg_q;
  logic                 sat_q;

  logic [DIV_NUM_W-1:0] mag;
  logic [DIV_NUM_W-1:0] madd;
  logic [DIV_NUM_W-1:0] dt_w;
  logic                 fit;
  logic [MV_W-1:0]      qv;

  assign dt_w = DIV_NUM_W'(dt_i);
  assign mag  = num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
  assign madd = mag + (dt_w << 9);
  assign fit  = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 4'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= madd;
      dsh_q <= dt_w << (10 + DIV_QB - 1);
      sat_q <= madd >= (dt_w << (10 + DIV_QB));
      neg_q <= num_i[DIV_NUM_W-1];
      cnt_q <= 4'(DIV_QB - 1);
      q_q   <= '0;
    end else if (busy_q) begin
      if (fit) begin
        rem_q <= rem_q - dsh_q;
      end
      q_q   <= {q_q[DIV_QB-2:0], fit};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_comb begin
    if (sat_q || MV_W'(q_q) > MV_W'(CLIP_MV)) begin
      qv = MV_W'(CLIP_MV);
    end else begin
      qv = MV_W'(q_q);
    end
  end

  assign quo_o  = neg_q ? -$signed(qv) : $signed(qv);
  assign done_o = done_q;

endmodule

@@ sv/marker_tracking_velocity_command.sv @@
// Marker tracking velocity command.
// Input channel (in_valid_i / in_stall_o) carries one beat per item: func 0 is a
// marker report, func 1 a control tick, func 2 clears the filters and the window.
// Reports and clears give no result; the block stays idle. A tick gives one result
// beat on the output channel (out_valid_o / out_stall_i).
// A tick first prunes the window: in S_PRD and S_PCK it reads and compares the
// oldest ring stamp and drops it while it is stale. Then the 33 sequencer steps
// run, using the shared multiply-accumulate unit, two of them starting divisions
// for the marker velocity terms. The next item is taken once the tick is through;
// the input stalls meanwhile.
// The finished result sits in an output register, so new items are taken while
// it waits; a later tick holds at its last step until that register is free.
// Reset loads the register defaults (lost 2 s, cone 1.0, rate 5/s, window
// 1000 ms) and clears filters, marker flag and window. Configuration writes are
// taken any time the block is idle.
module marker_tracking_velocity_command
  import mtvc_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        now_ms_i,
  input  logic signed [17:0] marker_x_i,
  input  logic signed [17:0] marker_y_i,
  input  logic [16:0]        marker_z_i,
  input  logic               marker_seen_i,
  input  logic [15:0]        dt_ms_i,
  input  logic signed [16:0] beacon_north_vel_i,
  input  logic signed [16:0] beacon_east_vel_i,
  input  logic signed [15:0] yaw_cos_i,
  input  logic signed [15:0] yaw_sin_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] vel_north_o,
  output logic signed [16:0] vel_east_o,
  output logic signed [9:0]  vel_up_o,
  output logic [5:0]         window_count_o,
  output logic               marker_valid_o
);

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic signed [9:0] UP_CLIMB = 10'sd200;
  localparam logic signed [9:0] UP_DESC  = -10'sd300;
  localparam logic signed [9:0] UP_HOLD  = 10'sd0;

  // sequencer steps of the shared multiply-accumulate unit
  localparam logic [5:0] U_ZC   = 6'd0;  // z*cone
  localparam logic [5:0] U_TT   = 6'd1;  // -(t*t)
  localparam logic [5:0] U_X5   = 6'd2;  // +(512x)^2
  localparam logic [5:0] U_Y5   = 6'd3;  // +(512y)^2
  localparam logic [5:0] U_X1   = 6'd4;  // (100x)^2
  localparam logic [5:0] U_Y1   = 6'd5;  // +(100y)^2
  localparam logic [5:0] U_Z5   = 6'd6;  // -(53z)^2
  localparam logic [5:0] U_BN   = 6'd7;  // c*bn
  localparam logic [5:0] U_BE   = 6'd8;  // +s*be
  localparam logic [5:0] U_BY0  = 6'd9;  // c*be
  localparam logic [5:0] U_BY1  = 6'd10; // -s*bn
  localparam logic [5:0] U_PV0  = 6'd11;
  localparam logic [5:0] U_PV0B = 6'd12;
  localparam logic [5:0] U_PV1  = 6'd13;
  localparam logic [5:0] U_PV1B = 6'd14;
  localparam logic [5:0] U_M0   = 6'd15;
  localparam logic [5:0] U_M0B  = 6'd16;
  localparam logic [5:0] U_M1   = 6'd17;
  localparam logic [5:0] U_M1B  = 6'd18;
  localparam logic [5:0] U_M2   = 6'd19;
  localparam logic [5:0] U_M2B  = 6'd20;
  localparam logic [5:0] U_V0   = 6'd21;
  localparam logic [5:0] U_V0B  = 6'd22;
  localparam logic [5:0] U_V0C  = 6'd23;
  localparam logic [5:0] U_D0   = 6'd24;
  localparam logic [5:0] U_V1   = 6'd25;
  localparam logic [5:0] U_V1B  = 6'd26;
  localparam logic [5:0] U_V1C  = 6'd27;
  localparam logic [5:0] U_D1   = 6'd28;
  localparam logic [5:0] U_RN   = 6'd29;
  localparam logic [5:0] U_RNB  = 6'd30;
  localparam logic [5:0] U_RE   = 6'd31;
  localparam logic [5:0] U_REB  = 6'd32;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRD  = 6'b000010,
    S_PCK  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q;
  logic [5:0] step_q;

  // configuration
  logic [24:0] lost_ms_q;
  logic [15:0] cone_q;
  logic [7:0]  thr_q;
  logic [15:0] win_q;
  logic [23:0] rate_lim_q;

  // tracking state
  logic signed [17:0] pos_q [3];
  logic signed [17:0] sm_q [3];
  logic signed [17:0] prev_q [3];
  logic signed [16:0] spv_q [2];
  logic signed [MV_W-1:0] mv_q [2];
  logic               flag_q;
  logic [31:0]        last_seen_q;
  logic [IDX_W-1:0]   head_q;
  logic [CNT_W-1:0]   count_q;
  logic signed [9:0]  lvc_q;

  // detection time stamp ring
  logic [31:0] ring_mem [WINDOW_DEPTH];
  logic [31:0] rd_q;

  // latched tick item and temporaries
  logic [31:0]        now_q;
  logic [15:0]        dt_q;
  logic signed [16:0] bn_q, be_q;
  logic signed [15:0] c_q, s_q;
  logic               lost_q;
  logic               tbig_q;
  logic               inside_q;
  logic signed [9:0]  up_q;
  logic signed [16:0] bx_q, by_q;
  logic signed [16:0] vn_q;

  // output register
  logic               out_valid_q;
  logic signed [16:0] out_vn_q, out_ve_q;
  logic signed [9:0]  out_up_q;
  logic [5:0]         out_cnt_q;
  logic               out_flag_q;

  logic                    in_acc;
  logic                    lost_now;
  logic                    out_free;
  logic [CNT_W:0]          tail_sum;
  logic [CNT_W:0]          tail_idx;
  logic [CNT_W+9:0]        cnt_k;
  logic                    rate_ok;
  logic                    stale;
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_r10, acc_r14;
  logic                    div_start;
  logic                    div_done;
  logic signed [MV_W-1:0]  div_quo;
  logic [CNT_W+5:0]        cnt_ext;
  logic signed [9:0]       up_pick;

  logic signed [MUL_W-1:0] x_w, y_w, z_w, x512, y512, x100, y100, z53;
  logic signed [MUL_W-1:0] c_w, s_w, dt_w, vx_w, vy_w;

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign lost_now   = (now_ms_i - last_seen_q) > 32'(lost_ms_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // oldest ring entry
  assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(WINDOW_DEPTH) - (CNT_W+1)'(count_q);
  assign tail_idx = (tail_sum >= (CNT_W+1)'(WINDOW_DEPTH)) ?
                    tail_sum - (CNT_W+1)'(WINDOW_DEPTH) : tail_sum;
  assign stale    = (now_q - rd_q) > 32'(win_q);

  assign cnt_k   = (CNT_W+10)'(count_q) * (CNT_W+10)'(1000);
  assign rate_ok = (CNT_W+34)'(cnt_k) > (CNT_W+34)'(rate_lim_q);
  assign cnt_ext = (CNT_W+6)'(count_q);

  assign acc_r10 = rnd_shift(acc, 10);
  assign acc_r14 = rnd_shift(acc, 14);

  // operand shapes; constant scalings are shift-adds
  assign x_w  = MUL_W'(pos_q[0]);
  assign y_w  = MUL_W'(pos_q[1]);
  assign z_w  = MUL_W'(pos_q[2]);
  assign x512 = x_w <<< 9;
  assign y512 = y_w <<< 9;
  assign x100 = (x_w <<< 6) + (x_w <<< 5) + (x_w <<< 2);
  assign y100 = (y_w <<< 6) + (y_w <<< 5) + (y_w <<< 2);
  assign z53  = (z_w <<< 5) + (z_w <<< 4) + (z_w <<< 2) + z_w;
  assign c_w  = MUL_W'(c_q);
  assign s_w  = MUL_W'(s_q);
  assign dt_w = MUL_W'($signed({1'b0, dt_q}));
  assign vx_w = MUL_W'(spv_q[0]) + (flag_q ? MUL_W'(mv_q[0]) : MUL_W'(0));
  assign vy_w = MUL_W'(spv_q[1]) + (flag_q ? MUL_W'(mv_q[1]) : MUL_W'(0));

  // vertical command from the cone tests
  always_comb begin
    if (inside_q) begin
      up_pick = UP_DESC;
    end else if (acc > 0) begin
      up_pick = UP_CLIMB;
    end else begin
      up_pick = UP_HOLD;
    end
  end

  // micro-step decode
  always_comb begin
    mac_ctl.en = (state_q == S_MUL) && (step_q != U_D0) && (step_q != U_D1);
    mac_ctl.op = MAC_LOAD;
    mac_a      = '0;
    mac_b      = '0;
    case (step_q)
      U_ZC:   begin mac_a = z_w; mac_b = MUL_W'($signed({1'b0, cone_q})); end
      U_TT:   begin
        mac_a = MUL_W'($signed({1'b0, acc[31:0]}));
        mac_b = MUL_W'($signed({1'b0, acc[31:0]}));
        mac_ctl.op = MAC_NEG;
      end
      U_X5:   begin mac_a = x512; mac_b = x512; mac_ctl.op = MAC_ADD; end
      U_Y5:   begin mac_a = y512; mac_b = y512; mac_ctl.op = MAC_ADD; end
      U_X1:   begin mac_a = x100; mac_b = x100; end
      U_Y1:   begin mac_a = y100; mac_b = y100; mac_ctl.op = MAC_ADD; end
      U_Z5:   begin mac_a = z53; mac_b = z53; mac_ctl.op = MAC_SUB; end
      U_BN:   begin mac_a = c_w; mac_b = MUL_W'(bn_q); end
      U_BE:   begin mac_a = s_w; mac_b = MUL_W'(be_q); mac_ctl.op = MAC_ADD; end
      U_BY0:  begin mac_a = c_w; mac_b = MUL_W'(be_q); end
      U_BY1:  begin mac_a = s_w; mac_b = MUL_W'(bn_q); mac_ctl.op = MAC_SUB; end
      U_PV0:  begin mac_a = MUL_W'(W_PAD_NEW); mac_b = MUL_W'(bx_q); end
      U_PV0B: begin
        mac_a = MUL_W'(W_PAD_OLD); mac_b = MUL_W'(spv_q[0]); mac_ctl.op = MAC_ADD;
      end
      U_PV1:  begin mac_a = MUL_W'(W_PAD_NEW); mac_b = MUL_W'(by_q); end
      U_PV1B: begin
        mac_a = MUL_W'(W_PAD_OLD); mac_b = MUL_W'(spv_q[1]); mac_ctl.op = MAC_ADD;
      end
      U_M0:   begin mac_a = MUL_W'(W_POS_NEW); mac_b = x_w; end
      U_M0B:  begin
        mac_a = MUL_W'(W_POS_OLD); mac_b = MUL_W'(sm_q[0]); mac_ctl.op = MAC_ADD;
      end
      U_M1:   begin mac_a = MUL_W'(W_POS_NEW); mac_b = y_w; end
      U_M1B:  begin
        mac_a = MUL_W'(W_POS_OLD); mac_b = MUL_W'(sm_q[1]); mac_ctl.op = MAC_ADD;
      end
      U_M2:   begin mac_a = MUL_W'(W_POS_NEW); mac_b = z_w; end
      U_M2B:  begin
        mac_a = MUL_W'(W_POS_OLD); mac_b = MUL_W'(sm_q[2]); mac_ctl.op = MAC_ADD;
      end
      U_V0:   begin mac_a = MUL_W'(K_DAMP); mac_b = MUL_W'(sm_q[0]); end
      U_V0B, U_V1B: begin mac_a = MUL_W'(acc[MUL_W-1:0]); mac_b = dt_w; end
      U_V0C:  begin
        mac_a = MUL_W'(K_DIFF); mac_b = MUL_W'(sm_q[0]) - MUL_W'(prev_q[0]);
        mac_ctl.op = MAC_ADD;
      end
      U_V1:   begin mac_a = MUL_W'(K_DAMP); mac_b = MUL_W'(sm_q[1]); end
      U_V1C:  begin
        mac_a = MUL_W'(K_DIFF); mac_b = MUL_W'(sm_q[1]) - MUL_W'(prev_q[1]);
        mac_ctl.op = MAC_ADD;
      end
      U_RN:   begin mac_a = c_w; mac_b = vx_w; end
      U_RNB:  begin mac_a = s_w; mac_b = vy_w; mac_ctl.op = MAC_SUB; end
      U_RE:   begin mac_a = s_w; mac_b = vx_w; end
      U_REB:  begin mac_a = c_w; mac_b = vy_w; mac_ctl.op = MAC_ADD; end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  assign div_start = (state_q == S_MUL) && ((step_q == U_D0) || (step_q == U_D1));

  mtvc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  mtvc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ($signed(acc[DIV_NUM_W-1:0])),
    .dt_i    (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ring storage, registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FUNC_REPORT && marker_seen_i) begin
      ring_mem[head_q] <= now_ms_i;
    end
    rd_q <= ring_mem[tail_idx[IDX_W-1:0]];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_ms_q  <= 25'd2000;
      cone_q     <= 16'd256;
      thr_q      <= 8'd5;
      win_q      <= 16'd1000;
      rate_lim_q <= 24'd5000;
    end else begin
      rate_lim_q <= 24'(thr_q) * 24'(win_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOST: lost_ms_q <= 25'(cfg_data_i[14:0]) * 25'd1000;
          REG_CONE: cone_q    <= cfg_data_i;
          REG_RATE: thr_q     <= cfg_data_i[7:0];
          REG_WIN:  win_q     <= cfg_data_i;
          default:  ;
        endcase
      end
    end
  end

  // sequencer and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      flag_q      <= 1'b0;
      last_seen_q <= '0;
      head_q      <= '0;
      count_q     <= '0;
      lvc_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        sm_q[i]   <= '0;
        prev_q[i] <= '0;
      end
      spv_q[0] <= '0;
      spv_q[1] <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (func_i)
              FUNC_REPORT: begin
                if (marker_seen_i) begin
                  pos_q[0]    <= marker_x_i;
                  pos_q[1]    <= marker_y_i;
                  pos_q[2]    <= $signed({1'b0, marker_z_i});
                  flag_q      <= 1'b1;
                  last_seen_q <= now_ms_i;
                  head_q      <= (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
                  if (count_q < CNT_W'(WINDOW_DEPTH)) begin
                    count_q <= count_q + 1'b1;
                  end
                end else if (lost_now) begin
                  flag_q <= 1'b0;
                end
              end
              FUNC_TICK: begin
                now_q   <= now_ms_i;
                dt_q    <= (dt_ms_i == 16'd0) ? 16'd1 : dt_ms_i;
                bn_q    <= beacon_north_vel_i;
                be_q    <= beacon_east_vel_i;
                c_q     <= yaw_cos_i;
                s_q     <= yaw_sin_i;
                lost_q  <= lost_now;
                state_q <= S_PRD;
              end
              FUNC_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                  sm_q[i]   <= '0;
                  prev_q[i] <= '0;
                end
                spv_q[0]    <= '0;
                spv_q[1]    <= '0;
                last_seen_q <= now_ms_i;
                head_q      <= '0;
                count_q     <= '0;
                lvc_q       <= '0;
              end
              default: ;
            endcase
          end
        end
        S_PRD: begin
          // ring read address settles this cycle
          if (count_q == '0) begin
            state_q <= S_MUL;
            step_q  <= U_ZC;
          end else begin
            state_q <= S_PCK;
          end
        end
        S_PCK: begin
          if (stale) begin
            count_q <= count_q - 1'b1;
            state_q <= S_PRD;
          end else begin
            state_q <= S_MUL;
            step_q  <= U_ZC;
          end
        end
        S_MUL: begin
          step_q <= step_q + 6'd1;
          case (step_q)
            U_TT:  tbig_q   <= |acc[ACC_W-1:32];
            U_X1:  inside_q <= tbig_q || (acc <= 0);
            U_BN: begin
              if (lost_q) begin
                up_q <= UP_CLIMB;
              end else if (flag_q) begin
                up_q  <= up_pick;
                lvc_q <= up_pick;
              end else if (rate_ok) begin
                up_q <= lvc_q;
              end else begin
                up_q <= UP_HOLD;
              end
            end
            U_BY0: bx_q <= 17'(sat_acc(acc_r14, ACC_W'(LIM_PAD_LO), ACC_W'(LIM_PAD_HI)));
            U_PV0: by_q <= 17'(sat_acc(acc_r14, ACC_W'(LIM_PAD_LO), ACC_W'(LIM_PAD_HI)));
            U_PV1: spv_q[0] <= 17'(acc_r10);
            U_M0:  spv_q[1] <= 17'(acc_r10);
            U_M1: begin
              if (flag_q) begin
                prev_q[0] <= sm_q[0];
                sm_q[0]   <= 18'(acc_r10);
              end
            end
            U_M2: begin
              if (flag_q) begin
                prev_q[1] <= sm_q[1];
                sm_q[1]   <= 18'(acc_r10);
              end
            end
            U_V0: begin
              if (flag_q) begin
                prev_q[2] <= sm_q[2];
                sm_q[2]   <= 18'(acc_r10);
              end
            end
            U_D0, U_D1: begin
              state_q <= S_DIV;
              step_q  <= step_q;
            end
            U_RE: vn_q <= 17'(sat_acc(acc_r14, ACC_W'(-LIM_VEL), ACC_W'(LIM_VEL)));
            U_REB: state_q <= S_DONE;
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            if (step_q == U_D1) begin
              mv_q[1] <= div_quo;
            end else begin
              mv_q[0] <= div_quo;
            end
            step_q  <= step_q + 6'd1;
            state_q <= S_MUL;
          end
        end
        S_DONE: begin
          // result waits here while an earlier beat is still held
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_vn_q    <= vn_q;
            out_ve_q    <= 17'(sat_acc(acc_r14, ACC_W'(-LIM_VEL), ACC_W'(LIM_VEL)));
            out_up_q    <= up_q;
            out_cnt_q   <= cnt_ext[5:0];
            out_flag_q  <= flag_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vel_north_o    = out_vn_q;
  assign vel_east_o     = out_ve_q;
  assign vel_up_o       = out_up_q;
  assign window_count_o = out_cnt_q;
  assign marker_valid_o = out_flag_q;

endmodule

@@ bench/marker_tracking_velocity_command_test.sv @@
module marker_tracking_velocity_command_test;
  import mtvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = int'(WINDOW_DEPTH_DEF);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic [31:0] now_ms_i = '0;
  logic signed [17:0] marker_x_i = '0;
  logic signed [17:0] marker_y_i = '0;
  logic [16:0] marker_z_i = '0;
  logic marker_seen_i = 1'b0;
  logic [15:0] dt_ms_i = '0;
  logic signed [16:0] beacon_north_vel_i = '0;
  logic signed [16:0] beacon_east_vel_i = '0;
  logic signed [15:0] yaw_cos_i = '0;
  logic signed [15:0] yaw_sin_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [16:0] vel_north_o;
  logic signed [16:0] vel_east_o;
  logic signed [9:0] vel_up_o;
  logic [5:0] window_count_o;
  logic marker_valid_o;

  marker_tracking_velocity_command DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct {
    logic [1:0] fn;
    logic [31:0] now;
    logic signed [17:0] mx, my;
    logic [16:0] mz;
    logic seen;
    logic [15:0] dt;
    logic signed [16:0] bn, be;
    logic signed [15:0] yc, ys;
  } item_t;

  typedef struct {
    logic signed [16:0] vn, ve;
    logic signed [9:0] up;
    logic [5:0] cnt;
    logic flag;
  } cmd_t;

  cmd_t cmd_queue[$];
  int errors = 0;

  // Predictor state, kept in wide signed integers
  longint unsigned p_lost, p_cone, p_rate, p_win;
  longint pos[3], spos[3], ppos[3], spad[2], last_up;
  bit flag;
  logic [31:0] seen_ms, now_clk;
  logic [31:0] ring[DEPTH];
  int head, cnt;

  function automatic longint rdiv(longint n, longint d);
    longint unsigned mag, q;
    mag = n < 0 ? -n : n;
    q = (mag + d / 2) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic clear_tracking(logic [31:0] t);
    for (int i = 0; i < 3; i++) begin
      spos[i] = 0;
      ppos[i] = 0;
    end
    spad[0] = 0;
    spad[1] = 0;
    seen_ms = t;
    head = 0;
    cnt = 0;
    last_up = 0;
  endtask

  // Advance the predicted state by one beat; queue the command a tick makes
  task automatic predict_command(item_t it);
    logic [31:0] age;
    bit lost, ins;
    longint dt, c, s, up, vx, vy, bx, by, x, y, z, mv0, mv1, num;
    longint unsigned sq, t;
    cmd_t r;
    age = it.now - seen_ms;
    lost = age > 32'(p_lost * 1000);
    case (it.fn)
      FUNC_REPORT: begin
        if (it.seen) begin
          pos[0] = it.mx;
          pos[1] = it.my;
          pos[2] = it.mz;
          flag = 1;
          seen_ms = it.now;
          ring[head] = it.now;
          head = (head + 1) % DEPTH;
          if (cnt < DEPTH) cnt++;
        end else if (lost) flag = 0;
      end
      FUNC_CLEAR: clear_tracking(it.now);
      FUNC_TICK: begin
        dt = it.dt == 0 ? 1 : it.dt;
        c = it.yc;
        s = it.ys;
        // drop stamps that fell out of the window, oldest first
        while (cnt > 0) begin
          age = it.now - ring[(head + DEPTH - cnt) % DEPTH];
          if (age > 32'(p_win)) cnt--;
          else break;
        end
        if (lost) up = 200;
        else if (flag) begin
          x = pos[0];
          y = pos[1];
          z = pos[2];
          sq = x * x + y * y;
          t = z * p_cone;
          ins = (t >= 64'h1_0000_0000) || (262144 * sq <= t * t);
          if (ins) up = -300;
          else if (10000 * sq > 2809 * z * z) up = 200;
          else up = 0;
          last_up = up;
        end else if (cnt * 1000 > p_rate * p_win) up = last_up;
        else up = 0;
        bx = clip(rdiv(c * it.bn + s * it.be, 16384), -65536, 65535);
        by = clip(rdiv(c * it.be - s * it.bn, 16384), -65536, 65535);
        spad[0] = rdiv(717 * bx + 307 * spad[0], 1024);
        spad[1] = rdiv(717 * by + 307 * spad[1], 1024);
        vx = spad[0];
        vy = spad[1];
        if (flag) begin
          for (int i = 0; i < 3; i++) begin
            ppos[i] = spos[i];
            spos[i] = rdiv(819 * pos[i] + 205 * spos[i], 1024);
          end
          num = 614 * spos[0] * dt + 40960 * (spos[0] - ppos[0]);
          mv0 = clip(rdiv(num, 1024 * dt), -5000, 5000);
          num = 614 * spos[1] * dt + 40960 * (spos[1] - ppos[1]);
          mv1 = clip(rdiv(num, 1024 * dt), -5000, 5000);
          vx += mv0;
          vy += mv1;
        end
        r.vn = 17'(clip(rdiv(c * vx - s * vy, 16384), -60000, 60000));
        r.ve = 17'(clip(rdiv(s * vx + c * vy, 16384), -60000, 60000));
        r.up = 10'(up);
        r.cnt = 6'(cnt);
        r.flag = flag;
        cmd_queue.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Output side: random stall, compare each result beat with the oldest entry
  int stall_left = 0;
  always @(posedge clk_i) begin
    cmd_t e;
    if (out_valid_o && !out_stall_i) begin
      if (cmd_queue.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = cmd_queue.pop_front();
        if (vel_north_o !== e.vn) begin
          $error("vel_north exp %0d got %0d", e.vn, vel_north_o); errors++;
        end
        if (vel_east_o !== e.ve) begin
          $error("vel_east exp %0d got %0d", e.ve, vel_east_o); errors++;
        end
        if (vel_up_o !== e.up) begin
          $error("vel_up exp %0d got %0d", e.up, vel_up_o); errors++;
        end
        if (window_count_o !== e.cnt) begin
          $error("window_count exp %0d got %0d", e.cnt, window_count_o); errors++;
        end
        if (marker_valid_o !== e.flag) begin
          $error("marker_valid exp %0d got %0d", e.flag, marker_valid_o); errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                               : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 11) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
  endfunction

  // Send one beat, then advance the predictor; valid drops only for a gap
  task automatic send_item(item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i <= it.fn;
    now_ms_i <= it.now;
    marker_x_i <= it.mx;
    marker_y_i <= it.my;
    marker_z_i <= it.mz;
    marker_seen_i <= it.seen;
    dt_ms_i <= it.dt;
    beacon_north_vel_i <= it.bn;
    beacon_east_vel_i <= it.be;
    yaw_cos_i <= it.yc;
    yaw_sin_i <= it.ys;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk_i);
    // a report or clear may still be in flight behind the last result
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LOST:   p_lost = val & 16'h7FFF;
      REG_CONE:   p_cone = val;
      REG_RATE:   p_rate = val & 16'h00FF;
      default:    p_win = val;
    endcase
  endtask

  task automatic set_config(int lost, int cone, int rate, int win);
    wait_idle();
    write_reg(REG_LOST, 16'(lost));
    write_reg(REG_CONE, 16'(cone));
    write_reg(REG_RATE, 16'(rate));
    write_reg(REG_WIN, 16'(win));
  endtask

  function automatic item_t make_item(logic [1:0] fn);
    item_t it;
    it.fn = fn;
    now_clk += $urandom_range(0, 3) == 0 ? $urandom_range(0, 5000) : $urandom_range(0, 60);
    it.now = now_clk;
    it.mx = $signed(18'($urandom_range(0, 200000))) - 18'sd100000;
    it.my = $signed(18'($urandom_range(0, 200000))) - 18'sd100000;
    it.mz = $urandom_range(0, 100000);
    it.seen = $urandom_range(0, 3) != 0;
    it.dt = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(1, 60));
    it.bn = 17'($urandom_range(0, 100000)) - 17'sd50000;
    it.be = 17'($urandom_range(0, 100000)) - 17'sd50000;
    it.yc = 16'($urandom_range(0, 32768)) - 16'sd16384;
    it.ys = 16'($urandom_range(0, 32768)) - 16'sd16384;
    if ($urandom_range(0, 30) == 0) begin
      it.yc = 16'($urandom);
      it.ys = 16'($urandom);
      it.mx = 18'($urandom);
      it.my = 18'($urandom);
      it.mz = 17'($urandom);
      it.bn = 17'($urandom);
      it.be = 17'($urandom);
    end
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    // extremes of every field, each code, zero dt, out-of-range yaw
    it = make_item(FUNC_REPORT);
    it.seen = 1; it.mx = 100000; it.my = -100000; it.mz = 100000;
    send_item(it);
    it = make_item(FUNC_TICK);
    it.dt = 0; it.bn = 50000; it.be = -50000; it.yc = 16384; it.ys = -16384;
    send_item(it);
    it = make_item(FUNC_TICK);
    it.dt = 16'hFFFF; it.yc = 16'sh7FFF; it.ys = 16'sh8000;
    it.bn = -17'sd65536; it.be = 17'sd65535;
    send_item(it);
    it = make_item(FUNC_UNUSED);
    send_item(it);
    it = make_item(FUNC_REPORT);
    it.seen = 1; it.mx = 0; it.my = 0; it.mz = 0;
    send_item(it);
    it = make_item(FUNC_TICK);
    send_item(it);
    it = make_item(FUNC_REPORT);
    it.seen = 0; it.now = now_clk + 32'd100000; now_clk = it.now;
    send_item(it);
    it = make_item(FUNC_TICK);
    send_item(it);
    it = make_item(FUNC_CLEAR);
    send_item(it);
    it = make_item(FUNC_TICK);
    it.now = 32'hFFFF_FFFF; now_clk = it.now;
    send_item(it);
    it = make_item(FUNC_REPORT);
    it.seen = 1; it.now = 32'd5; now_clk = it.now;
    send_item(it);
    it = make_item(FUNC_TICK);
    send_item(it);
  endtask

  // Bursts of reports followed by ticks, with occasional clears and noise
  task automatic test_random(int n);
    int k;
    k = 0;
    while (k < n) begin
      repeat ($urandom_range(0, 40)) begin
        send_item(make_item(FUNC_REPORT));
        k++;
      end
      repeat ($urandom_range(1, 4)) begin
        send_item(make_item(FUNC_TICK));
        k++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item($urandom_range(0, 9) == 0 ? FUNC_UNUSED : FUNC_CLEAR));
        k++;
      end
    end
  endtask

  initial begin
    p_lost = 2; p_cone = 256; p_rate = 5; p_win = 1000;
    for (int i = 0; i < 3; i++) pos[i] = 0;
    flag = 0;
    now_clk = 0;
    for (int i = 0; i < DEPTH; i++) ring[i] = '0;
    clear_tracking(0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(100);
    set_config(0, 0, 0, 0);
    test_random(60);
    set_config(32767, 65535, 255, 65535);
    test_random(60);
    set_config(1, 300, 2, 1);
    test_random(100);
    set_config($urandom_range(0, 5), $urandom_range(100, 900), $urandom_range(0, 40),
               $urandom_range(50, 3000));
    test_random(120);
    in_valid_i <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ sim.f @@
sv/mtvc_pkg.sv
sv/mtvc_mac.sv
sv/mtvc_div.sv
sv/marker_tracking_velocity_command.sv
bench/marker_tracking_velocity_command_test.sv
